// ----- sv/assert_macros.svh -----
// Assertion helpers, included by the SELU core design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/selu_pkg.sv -----
`default_nettype none

package selu_pkg;

  // Field widths.
  localparam int X_W       = 24;
  localparam int CFG_W     = 20;
  localparam int OUT_W     = 32;
  localparam int FRAC_BITS = 16;

  // exp values are Q0.16 in [0, 1.0], so they need one extra bit.
  localparam int E_W    = FRAC_BITS + 1;
  localparam int PAIR_W = 2 * E_W;

  // The grid is nonzero only for integer parts below this power of two.
  localparam int GRID_INT_BITS = 4;
  localparam int SERIES_TERMS  = 24;

  // Datapath widths.
  localparam int P_W      = 2 * CFG_W;
  localparam int S_W      = P_W - FRAC_BITS;
  localparam int PE_W     = P_W + E_W;
  localparam int A_W      = PE_W - 2 * FRAC_BITS;
  localparam int DIFF_W   = A_W + 1;
  localparam int POSMUL_W = CFG_W + 1 + X_W;
  localparam int POSV_W   = POSMUL_W - FRAC_BITS;

  // Register reset values.
  localparam logic [CFG_W-1:0] ALPHA_RESET  = 20'd109660;
  localparam logic [CFG_W-1:0] LAMBDA_RESET = 20'd68859;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd1;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  // Shift-subtract division, used only while building the exp table.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // exp(-k / 2^b) in Q0.32 from a truncated Taylor sum in Q.40.
  function automatic longint unsigned exp_frac_q32(input int k, input int b);
    longint unsigned term;
    longint unsigned steps;
    longint sum;
    term  = 64'd1 << 40;
    steps = 64'd1 << b;
    sum   = longint'(term);
    for (int i = 1; i <= SERIES_TERMS; i++) begin
      term = udiv64(term * longint'(k), steps * longint'(i));
      if ((i & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return (longint'(sum) + 64'd128) >> 8;
  endfunction

  // Grid point m: exp(-m / 2^b) in Q0.16.
  function automatic logic [E_W-1:0] grid_q16(input int m, input int b);
    int n;
    int k;
    longint unsigned g;
    longint unsigned e1;
    n = m >> b;
    k = m & ((1 << b) - 1);
    if (n >= (1 << GRID_INT_BITS)) begin
      return '0;
    end
    g  = exp_frac_q32(k, b);
    e1 = exp_frac_q32(1 << b, b);
    for (int i = 0; i < n; i++) begin
      g = (g * e1 + (64'd1 << 31)) >> 32;
    end
    return E_W'((g + (64'd1 << 15)) >> 16);
  endfunction

  // Both interpolation endpoints for segment m: upper half is point m + 1.
  function automatic logic [PAIR_W-1:0] grid_pair(input int m, input int b);
    return {grid_q16(m + 1, b), grid_q16(m, b)};
  endfunction

endpackage

`default_nettype wire

// ----- sv/selu_exp_rom.sv -----
`default_nettype none

// Two-stage lookup of the exp grid. Stage one reads every bank at the low
// index bits, stage two picks the bank and zeroes out-of-range inputs.
module selu_exp_rom #(
  parameter int EXP_TABLE_BITS = 6
) (
  input  wire logic                    clk,
  input  wire selu_pkg::pipe_en_t      en,
  input  wire logic [selu_pkg::X_W-1:0] u,
  output logic [selu_pkg::E_W-1:0]     t0,
  output logic [selu_pkg::E_W-1:0]     t1
);
  import selu_pkg::*;

  localparam int F_W    = FRAC_BITS - EXP_TABLE_BITS;
  localparam int IDX_W  = GRID_INT_BITS + EXP_TABLE_BITS;
  localparam int N_ENT  = 1 << IDX_W;
  localparam int SEL_W  = (EXP_TABLE_BITS > 5) ? (EXP_TABLE_BITS - GRID_INT_BITS) : 1;
  localparam int BANK_W = IDX_W - SEL_W;
  localparam int N_BANK = 1 << SEL_W;
  localparam int TOP    = F_W + IDX_W;

  logic [PAIR_W-1:0] rom_tbl [N_ENT];
  logic [PAIR_W-1:0] bank_q  [N_BANK];
  logic [SEL_W-1:0]  sel1;
  logic              range1;
  logic [PAIR_W-1:0] pair2;
  logic [BANK_W-1:0] low_idx;
  logic              in_range;

  // Constant grid, built at elaboration.
  for (genvar i = 0; i < N_ENT; i++) begin : g_tbl
    localparam logic [PAIR_W-1:0] ENTRY = grid_pair(i, EXP_TABLE_BITS);
    assign rom_tbl[i] = ENTRY;
  end

  // Inputs beyond the grid read as zero.
  assign in_range = (u[X_W-1:TOP] == '0);
  assign low_idx  = u[TOP-SEL_W-1:F_W];

  // Stage one: one read per bank.
  for (genvar j = 0; j < N_BANK; j++) begin : g_bank
    logic [IDX_W-1:0] addr;
    assign addr = {SEL_W'(j), low_idx};
    always_ff @(posedge clk) begin
      if (en.s1) begin
        bank_q[j] <= rom_tbl[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      sel1   <= u[TOP-1:TOP-SEL_W];
      range1 <= in_range;
    end
  end

  // Stage two: bank select.
  always_ff @(posedge clk) begin
    if (en.s2) begin
      pair2 <= range1 ? bank_q[sel1] : '0;
    end
  end

  assign t0 = pair2[E_W-1:0];
  assign t1 = pair2[PAIR_W-1:E_W];

endmodule

`default_nettype wire

// ----- sv/selu_interp.sv -----
`default_nettype none

// Linear interpolation between two grid points, registered.
module selu_interp #(
  parameter int EXP_TABLE_BITS = 6
) (
  input  wire logic                                            clk,
  input  wire selu_pkg::pipe_en_t                              en,
  input  wire logic [selu_pkg::E_W-1:0]                        t0,
  input  wire logic [selu_pkg::E_W-1:0]                        t1,
  input  wire logic [selu_pkg::FRAC_BITS-EXP_TABLE_BITS-1:0]   r,
  output logic [selu_pkg::E_W-1:0]                             e
);
  import selu_pkg::*;

  localparam int F_W   = FRAC_BITS - EXP_TABLE_BITS;
  localparam int SUM_W = E_W + F_W + 2;
  localparam logic [F_W:0]     W_FULL = (F_W + 1)'(1) << F_W;
  localparam logic [SUM_W-1:0] W_HALF = SUM_W'(1) << (F_W - 1);

  logic [F_W:0]     w_minus_r;
  logic [SUM_W-1:0] acc;

  // Weighted sum of the endpoints plus half a step for rounding.
  assign w_minus_r = W_FULL - (F_W + 1)'(r);
  assign acc = SUM_W'(t0 * w_minus_r) + SUM_W'(t1 * r) + W_HALF;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      e <= acc[F_W +: E_W];
    end
  end

endmodule

`default_nettype wire

// ----- sv/selu_activation_with_derivatives_core.sv -----
`default_nettype none

// SELU activation with first, second and third derivatives.
// Input channel: in_valid, in_stall, x_value (signed Q8.16) and the three
// want_* flags. A word is taken at a clock edge with in_valid high and
// in_stall low. Output channel: out_valid, out_stall and four signed Q16.16
// results; a word leaves at an edge with out_valid high and out_stall low.
// Stages to out_valid: grid bank read, bank select, interpolation, the 40x17
// alpha*lambda*exp product, then rounding and output. One word is accepted
// per cycle while the output drains. When out_stall is held, the output
// holds its word and the stages behind it keep filling their empty slots;
// in_stall rises only once all five stages hold words. rst is synchronous
// and active high: it empties the pipeline and restores alpha_q16 and
// lambda_q16 to their defaults. The user must write registers via cfg_we,
// cfg_index and cfg_data only while the pipeline is empty; the block does
// not enforce it. Index 0 is alpha_q16, 1 is lambda_q16, others are ignored.
module selu_activation_with_derivatives_core #(
  parameter int EXP_TABLE_BITS = 6
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [selu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [selu_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [selu_pkg::X_W-1:0]      x_value,
  input  wire logic                                 want_first,
  input  wire logic                                 want_second,
  input  wire logic                                 want_third,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [selu_pkg::OUT_W-1:0]         act_value,
  output logic signed [selu_pkg::OUT_W-1:0]         first_deriv,
  output logic signed [selu_pkg::OUT_W-1:0]         second_deriv,
  output logic signed [selu_pkg::OUT_W-1:0]         third_deriv
);
  import selu_pkg::*;

  `include "assert_macros.svh"

  localparam int F_W = FRAC_BITS - EXP_TABLE_BITS;
  localparam logic [POSMUL_W-1:0] POS_RND = POSMUL_W'(1) << (FRAC_BITS - 1);
  localparam logic [P_W-1:0]      S_RND   = P_W'(1) << (FRAC_BITS - 1);
  localparam logic [PE_W:0]       A_RND   = (PE_W + 1)'(1) << (2 * FRAC_BITS - 1);

  // Configuration registers.
  logic [CFG_W-1:0] alpha_q16;
  logic [CFG_W-1:0] lambda_q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q16  <= ALPHA_RESET;
      lambda_q16 <= LAMBDA_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ALPHA) begin
        alpha_q16 <= cfg_data;
      end else if (cfg_index == CFG_LAMBDA) begin
        lambda_q16 <= cfg_data;
      end
    end
  end

  // Stage valid bits and load enables; a stage loads when it is empty or
  // the stage after it moves on.
  logic     v1, v2, v3, v4, v5;
  pipe_en_t en;

  always_comb begin
    en.s5 = !v5 || !out_stall;
    en.s4 = !v4 || en.s5;
    en.s3 = !v3 || en.s4;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign in_stall  = !en.s1;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en.s1) v1 <= in_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
      if (en.s5) v5 <= v4;
    end
  end

  // Magnitude of a non-positive input, used as the exp argument.
  logic [X_W-1:0] u_in;
  assign u_in = X_W'(-x_value);

  logic [E_W-1:0] t0, t1, e3;

  selu_exp_rom #(
    .EXP_TABLE_BITS(EXP_TABLE_BITS)
  ) u_rom (
    .clk (clk),
    .en  (en),
    .u   (u_in),
    .t0  (t0),
    .t1  (t1)
  );

  logic [F_W-1:0] r1, r2;

  selu_interp #(
    .EXP_TABLE_BITS(EXP_TABLE_BITS)
  ) u_interp (
    .clk (clk),
    .en  (en),
    .t0  (t0),
    .t1  (t1),
    .r   (r2),
    .e   (e3)
  );

  // Flags and branch travel with the word.
  logic [2:0] want1, want2, want3, want4;
  logic       pos1, pos2, pos3, pos4, pos5;

  // Stage one: positive branch product.
  logic signed [POSMUL_W-1:0] posmul1;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      pos1    <= (x_value > 0);
      want1   <= {want_third, want_second, want_first};
      r1      <= u_in[F_W-1:0];
      posmul1 <= $signed({1'b0, lambda_q16}) * x_value;
    end
  end

  // Stage two: round the positive value, form alpha*lambda.
  logic [POSMUL_W-1:0]      posmul_rnd;
  logic signed [POSV_W-1:0] posv2, posv3, posv4;
  logic [P_W-1:0]           p2, p3;

  assign posmul_rnd = posmul1 + POS_RND;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      pos2  <= pos1;
      want2 <= want1;
      r2    <= r1;
      posv2 <= $signed(posmul_rnd[POSMUL_W-1:FRAC_BITS]);
      p2    <= P_W'(alpha_q16 * lambda_q16);
    end
  end

  // Stage three: rounded alpha*lambda offset; exp value comes from interp.
  logic [P_W-1:0] p_rnd;
  logic [S_W-1:0] s3, s4;

  assign p_rnd = p2 + S_RND;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      pos3  <= pos2;
      want3 <= want2;
      posv3 <= posv2;
      p3    <= p2;
      s3    <= p_rnd[P_W-1:FRAC_BITS];
    end
  end

  // Stage four: alpha*lambda*exp(x).
  logic [PE_W-1:0] pe4;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      pos4  <= pos3;
      want4 <= want3;
      posv4 <= posv3;
      s4    <= s3;
      pe4   <= PE_W'(p3 * e3);
    end
  end

  // Stage five: round the product and build the output word.
  logic [PE_W:0]            pe_rnd;
  logic [A_W-1:0]           a_val;
  logic signed [DIFF_W-1:0] diff;
  logic [OUT_W-1:0]         a_ext;
  logic [OUT_W-1:0]         lambda_ext;
  logic signed [OUT_W-1:0]  act_next, first_next, second_next, third_next;

  assign pe_rnd     = (PE_W + 1)'(pe4) + A_RND;
  assign a_val      = pe_rnd[2*FRAC_BITS +: A_W];
  assign diff       = $signed({1'b0, a_val}) - $signed(DIFF_W'(s4));
  assign a_ext      = OUT_W'(a_val);
  assign lambda_ext = OUT_W'(lambda_q16);

  always_comb begin
    if (pos4) begin
      act_next    = OUT_W'(posv4);
      first_next  = want4[0] ? $signed(lambda_ext) : '0;
      second_next = '0;
      third_next  = '0;
    end else begin
      act_next    = OUT_W'(diff);
      first_next  = want4[0] ? $signed(a_ext) : '0;
      second_next = want4[1] ? $signed(a_ext) : '0;
      third_next  = want4[2] ? $signed(a_ext) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      pos5         <= pos4;
      act_value    <= act_next;
      first_deriv  <= first_next;
      second_deriv <= second_next;
      third_deriv  <= third_next;
    end
  end

  // The input side only stalls when every stage holds a word.
  `ASSERT_CLK(a_stall_full, in_stall |-> (v1 && v2 && v3 && v4 && v5 && out_stall), "input stalled with a free stage")
  // An accepted word lands in stage one.
  `ASSERT_CLK(a_accept_lands, (in_valid && !in_stall) |=> v1, "accepted word lost at stage one")
  // On the exp branch the value lies between minus alpha*lambda and zero.
  `ASSERT_CLK(a_neg_range, (out_valid && !pos5) |-> (act_value <= 0), "exp branch value above zero")
  // Reset empties the output.
  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid right after reset")

endmodule

`default_nettype wire
